// ----- hdl/indexed_min_heap_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed min-heap queue
// Short forms for a condition that holds on every clock and for a cause that
// is followed by an effect in the next cycle.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH

// Condition holds on every clock outside reset
`define IMHQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent is followed by the consequent in the next cycle
`define IMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/imhq_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap queue package
// Field widths, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package imhq_pkg;

    localparam int ID_W     = 10;
    localparam int IN_KEY_W = 32;
    localparam int COUNT_W  = 11;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_INS,
        S_TAKE_A,
        S_TAKE_B,
        S_TAKE_C,
        S_UP,
        S_UP_CMP,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_PLACE,
        S_DROP,
        S_TOP,
        S_TOP_W,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/imhq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, then register the read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/indexed_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap queue
// Binary min-heap of node ids keyed by cost, with a per-node slot table.
// ----------------------------------------------------------------------------
//  channel  dir  ports                          payload
//  s_       in   s_tvalid s_tready s_tdata s_tuser  opcode, node_id, key
//  m_       out  m_tvalid m_tready m_tdata          result fields
//
//  One request at a time; a small sequencer drives the slot RAM and the node
//  RAM, one read each per cycle with registered data. A sift-up level reads
//  the parent and then compares; a sift-down level reads the left child, the
//  right child when there is one, then compares the smaller with the entry.
//  After reset a clearing pass writes every node RAM entry absent while
//  s_tready is low. A stalled result holds s_tready low until taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_min_heap_queue_assert.svh"

module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int HEAP_DEPTH = 1024,
    parameter int NODE_COUNT = 1024,
    parameter int KEY_BITS   = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // node_id[9:0], key[41:10], zero fill
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata    // taken_valid[0], taken_node[10:1],
                                        // top_valid[11], top_node[21:12],
                                        // top_key[53:22], entry_count[64:54],
                                        // status[67:65], zero fill
);

    localparam int SW  = $clog2(HEAP_DEPTH);
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int IW  = SW + 2;
    localparam int SEW = KEY_BITS + ID_W;
    localparam int NEW = SW + 1;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [SW-1:0]       pos_reg, pos_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [ID_W-1:0]     cur_node_reg, cur_node_next;
    logic [KEY_BITS-1:0] lkey_reg, lkey_next;
    logic [ID_W-1:0]     lnode_reg, lnode_next;
    logic [KEY_BITS-1:0] ckey_reg, ckey_next;
    logic [ID_W-1:0]     cnode_reg, cnode_next;
    logic [SW-1:0]       cidx_reg, cidx_next;
    logic                taking_reg, taking_next;
    logic                taken_valid_reg, taken_valid_next;
    logic [ID_W-1:0]     taken_node_reg, taken_node_next;
    logic [ID_W-1:0]     rm_node_reg, rm_node_next;
    status_t             status_reg, status_next;
    logic [NW-1:0]       clr_reg, clr_next;
    logic [71:0]         out_reg, out_next;

    // RAM ports
    logic            slot_we;
    logic [SW-1:0]   slot_wa, slot_ra;
    logic [SEW-1:0]  slot_wd, slot_rd;
    logic            node_we;
    logic [NW-1:0]   node_wa, node_ra;
    logic [NEW-1:0]  node_wd, node_rd;

    // Derived values
    logic [63:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic [16:0]         id_wide;
    logic [NW-1:0]       id_idx;
    logic                id_ok;
    logic [CW-1:0]       occ_m1;
    logic [SW-1:0]       last_slot;
    logic [SW-1:0]       pos_m1;
    logic [SW-1:0]       parent;
    logic [IW-1:0]       l_ext, r_ext, occ_ext;
    logic [KEY_BITS-1:0] rd_key;
    logic [ID_W-1:0]     rd_node;
    logic                n_present;
    logic [SW-1:0]       n_slot;
    logic                heap_full;
    logic [63:0]         top_key_wide;
    logic [16:0]         count_wide;

    function automatic logic [NW-1:0] nidx(input logic [ID_W-1:0] n);
        logic [16:0] w;
        w = {7'b0, n};
        return w[NW-1:0];
    endfunction

    assign key_wide  = {32'b0, s_tdata[41:10]};
    assign key_in    = key_wide[KEY_BITS-1:0];
    assign id_wide   = {7'b0, id_reg};
    assign id_idx    = id_wide[NW-1:0];
    assign id_ok     = id_wide < 17'(NODE_COUNT);
    assign occ_m1    = occ_reg - CW'(1);
    assign last_slot = occ_m1[SW-1:0];
    assign pos_m1    = pos_reg - SW'(1);
    assign parent    = pos_m1 >> 1;
    assign l_ext     = IW'({pos_reg, 1'b1});
    assign r_ext     = l_ext + IW'(1);
    assign occ_ext   = IW'(occ_reg);
    assign rd_key    = slot_rd[KEY_BITS-1:0];
    assign rd_node   = slot_rd[SEW-1:KEY_BITS];
    assign n_present = node_rd[SW];
    assign n_slot    = node_rd[SW-1:0];
    assign heap_full = occ_reg >= CW'(HEAP_DEPTH);
    assign top_key_wide = 64'(rd_key);
    assign count_wide   = 17'(occ_reg);

    imhq_ram #(.WIDTH(SEW), .DEPTH(HEAP_DEPTH)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_wa),
        .wr_data (slot_wd),
        .rd_addr (slot_ra),
        .rd_data (slot_rd)
    );

    imhq_ram #(.WIDTH(NEW), .DEPTH(NODE_COUNT)) u_node_ram (
        .aclk    (aclk),
        .wr_en   (node_we),
        .wr_addr (node_wa),
        .wr_data (node_wd),
        .rd_addr (node_ra),
        .rd_data (node_rd)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_reg == NW'(NODE_COUNT - 1)) state_next = S_IDLE;
            S_IDLE:   if (s_tvalid) state_next = S_LOOK;
            S_LOOK: begin
                if (op_reg == OP_POP) begin
                    state_next = (occ_reg == '0) ? S_TOP : S_TAKE_A;
                end else if (!id_ok) begin
                    state_next = S_TOP;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                unique case (op_reg)
                    OP_INSERT: state_next = n_present ? S_TOP : S_INS;
                    OP_REMOVE: state_next = n_present ? S_TAKE_A : S_TOP;
                    OP_UPDATE: state_next = n_present ? S_TAKE_A : S_INS;
                    default:   state_next = S_TOP;
                endcase
            end
            S_INS:    state_next = heap_full ? S_TOP : S_UP;
            S_TAKE_A: state_next = S_TAKE_B;
            S_TAKE_B: state_next = S_TAKE_C;
            S_TAKE_C: state_next = (s_reg != last_slot) ? S_UP : S_DROP;
            S_UP: begin
                if (pos_reg == '0) begin
                    state_next = taking_reg ? S_DN : S_PLACE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (rd_key > cur_key_reg) begin
                    state_next = S_UP;
                end else begin
                    state_next = taking_reg ? S_DN : S_PLACE;
                end
            end
            S_DN:     state_next = (l_ext >= occ_ext) ? S_PLACE : S_DN_L;
            S_DN_L:   state_next = (r_ext < occ_ext) ? S_DN_R : S_DN_CMP;
            S_DN_R:   state_next = S_DN_CMP;
            S_DN_CMP: state_next = (ckey_reg < cur_key_reg) ? S_DN : S_PLACE;
            S_PLACE:  state_next = taking_reg ? S_DROP : S_TOP;
            S_DROP:   state_next = (op_reg == OP_UPDATE) ? S_INS : S_TOP;
            S_TOP:    state_next = S_TOP_W;
            S_TOP_W:  state_next = S_OUT;
            S_OUT:    if (m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        op_next          = op_reg;
        id_next          = id_reg;
        key_next         = key_reg;
        occ_next         = occ_reg;
        pos_next         = pos_reg;
        s_next           = s_reg;
        cur_key_next     = cur_key_reg;
        cur_node_next    = cur_node_reg;
        lkey_next        = lkey_reg;
        lnode_next       = lnode_reg;
        ckey_next        = ckey_reg;
        cnode_next       = cnode_reg;
        cidx_next        = cidx_reg;
        taking_next      = taking_reg;
        taken_valid_next = taken_valid_reg;
        taken_node_next  = taken_node_reg;
        rm_node_next     = rm_node_reg;
        status_next      = status_reg;
        clr_next         = clr_reg;
        out_next         = out_reg;
        slot_we = 1'b0;
        slot_wa = pos_reg;
        slot_wd = {cur_node_reg, cur_key_reg};
        slot_ra = '0;
        node_we = 1'b0;
        node_wa = nidx(cur_node_reg);
        node_wd = {1'b1, pos_reg};
        node_ra = id_idx;

        unique case (state_reg)
            // Sweep the node table to absent
            S_CLEAR: begin
                node_we  = 1'b1;
                node_wa  = clr_reg;
                node_wd  = '0;
                clr_next = clr_reg + NW'(1);
            end
            // Latch the request
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next          = op_t'(s_tuser);
                    id_next          = s_tdata[ID_W-1:0];
                    key_next         = key_in;
                    taken_valid_next = 1'b0;
                    taken_node_next  = '0;
                    status_next      = ST_OK;
                    taking_next      = 1'b0;
                end
            end
            // Look up the node, settle pops and bad ids
            S_LOOK: begin
                if (op_reg == OP_POP) begin
                    if (occ_reg == '0) status_next = ST_EMPTY;
                    s_next = '0;
                end else if (!id_ok) begin
                    status_next = ST_ABSENT;
                end
            end
            S_CHECK: begin
                unique case (op_reg)
                    OP_INSERT: if (n_present) status_next = ST_PRESENT;
                    OP_REMOVE: begin
                        if (n_present) s_next = n_slot;
                        else status_next = ST_ABSENT;
                    end
                    OP_UPDATE: if (n_present) s_next = n_slot;
                    default: ;
                endcase
            end
            // Append at the end, then sift up; a full heap reports full instead
            S_INS: begin
                taking_next = 1'b0;
                if (heap_full) begin
                    status_next = ST_FULL;
                end else begin
                    pos_next      = occ_reg[SW-1:0];
                    occ_next      = occ_reg + CW'(1);
                    cur_key_next  = key_reg;
                    cur_node_next = id_reg;
                end
            end
            S_TAKE_A: begin
                slot_ra     = s_reg;
                taking_next = 1'b1;
            end
            // Record the removed node, fetch the last entry
            S_TAKE_B: begin
                rm_node_next = rd_node;
                if (op_reg != OP_UPDATE) begin
                    taken_valid_next = 1'b1;
                    taken_node_next  = rd_node;
                end
                slot_ra = last_slot;
            end
            // Move the last entry into the hole
            S_TAKE_C: begin
                cur_key_next  = rd_key;
                cur_node_next = rd_node;
                occ_next      = occ_m1;
                pos_next      = s_reg;
            end
            S_UP: begin
                slot_ra = parent;
            end
            // Pull a larger parent down into the hole
            S_UP_CMP: begin
                if (rd_key > cur_key_reg) begin
                    slot_we  = 1'b1;
                    slot_wd  = slot_rd;
                    node_we  = 1'b1;
                    node_wa  = nidx(rd_node);
                    pos_next = parent;
                end
            end
            S_DN: begin
                slot_ra = l_ext[SW-1:0];
            end
            S_DN_L: begin
                lkey_next  = rd_key;
                lnode_next = rd_node;
                slot_ra    = r_ext[SW-1:0];
                ckey_next  = rd_key;
                cnode_next = rd_node;
                cidx_next  = l_ext[SW-1:0];
            end
            // Left wins only when strictly smaller
            S_DN_R: begin
                if (lkey_reg < rd_key) begin
                    ckey_next  = lkey_reg;
                    cnode_next = lnode_reg;
                    cidx_next  = l_ext[SW-1:0];
                end else begin
                    ckey_next  = rd_key;
                    cnode_next = rd_node;
                    cidx_next  = r_ext[SW-1:0];
                end
            end
            // Lift a smaller child up into the hole
            S_DN_CMP: begin
                if (ckey_reg < cur_key_reg) begin
                    slot_we  = 1'b1;
                    slot_wd  = {cnode_reg, ckey_reg};
                    node_we  = 1'b1;
                    node_wa  = nidx(cnode_reg);
                    pos_next = cidx_reg;
                end
            end
            // Drop the moving entry into its final slot
            S_PLACE: begin
                slot_we = 1'b1;
                node_we = 1'b1;
            end
            // Mark the removed node absent
            S_DROP: begin
                node_we = 1'b1;
                node_wa = nidx(rm_node_reg);
                node_wd = '0;
            end
            S_TOP: begin
                slot_ra = '0;
            end
            // Assemble the result
            S_TOP_W: begin
                out_next        = '0;
                out_next[0]     = taken_valid_reg;
                out_next[10:1]  = taken_node_reg;
                if (occ_reg != '0) begin
                    out_next[11]    = 1'b1;
                    out_next[21:12] = rd_node;
                    out_next[53:22] = top_key_wide[31:0];
                end
                out_next[64:54] = count_wide[COUNT_W-1:0];
                out_next[67:65] = status_reg;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            occ_reg    <= '0;
            clr_reg    <= '0;
            taking_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            clr_reg    <= clr_next;
            taking_reg <= taking_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        id_reg          <= id_next;
        key_reg         <= key_next;
        pos_reg         <= pos_next;
        s_reg           <= s_next;
        cur_key_reg     <= cur_key_next;
        cur_node_reg    <= cur_node_next;
        lkey_reg        <= lkey_next;
        lnode_reg       <= lnode_next;
        ckey_reg        <= ckey_next;
        cnode_reg       <= cnode_next;
        cidx_reg        <= cidx_next;
        taken_valid_reg <= taken_valid_next;
        taken_node_reg  <= taken_node_next;
        rm_node_reg     <= rm_node_next;
        status_reg      <= status_next;
        out_reg         <= out_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = out_reg;

    `IMHQ_ASSERT_ALWAYS(a_occ_bound, aclk, aresetn, occ_reg <= CW'(HEAP_DEPTH), "occupancy above capacity")
    `IMHQ_ASSERT_ALWAYS(a_one_side, aclk, aresetn, !(s_tready && m_tvalid), "input and result open together")
    `IMHQ_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready && !m_tvalid, "accept not followed by busy")
    `IMHQ_ASSERT_NEXT(a_drop_next, aclk, aresetn, state_reg == S_DROP, state_reg == S_INS || state_reg == S_TOP, "bad step after node drop")

endmodule

`default_nettype wire
